/* src/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/dlrs_pkg.sv */
// shared constants and types of the decimal radix sorter
`timescale 1ns / 1ps
package dlrs_pkg;

  localparam int KeyW       = 20;
  localparam int DefMaxKeys = 64;
  localparam int DefKeyBits = 20;
  localparam int Radix      = 10;
  localparam int DigitW     = 4;
  localparam int RecipW     = 32;
  localparam int RecipShift = 35;
  localparam logic [RecipW-1:0] Recip10 = 32'hCCCC_CCCD;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_HIST,
    ST_HIST_DRAIN,
    ST_PREFIX,
    ST_SCAT,
    ST_SCAT_DRAIN,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_HOLD
  } state_e;

  typedef struct packed {
    logic              clr;
    logic              inc;
    logic              pfx;
    logic              dec;
    logic [DigitW-1:0] digit;
    logic [DigitW-1:0] idx;
  } hist_ctl_t;

endpackage

/* src/dlrs_div10.sv */
// registered divide-by-ten unit giving quotient and low decimal digit
`timescale 1ns / 1ps
module dlrs_div10 #(
  parameter int KEY_BITS = dlrs_pkg::DefKeyBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic [KEY_BITS-1:0]         quot_i,
  output logic                        out_valid_o,
  output logic [KEY_BITS-1:0]         key_o,
  output logic [KEY_BITS-1:0]         quot_o,
  output logic [dlrs_pkg::DigitW-1:0] digit_o
);
  import dlrs_pkg::*;

  localparam int ProdW = KEY_BITS + RecipW;
  localparam int QW    = KEY_BITS - 3;

  logic                v_q;
  logic [KEY_BITS-1:0] key_q;
  logic [KEY_BITS-1:0] q_q;
  logic [ProdW-1:0]    prod_q;
  logic [ProdW-1:0]    prod_d;
  logic [KEY_BITS-1:0] quot;
  logic [KEY_BITS-1:0] rem;

  // reciprocal multiply, exact for operands up to 32 bits
  assign prod_d = ProdW'(quot_i) * ProdW'(Recip10);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_i;
    q_q    <= quot_i;
    prod_q <= prod_d;
  end

  // quotient and remainder from the registered product
  assign quot = KEY_BITS'(prod_q[RecipShift +: QW]);
  assign rem  = q_q - (quot << 3) - (quot << 1);

  assign out_valid_o = v_q;
  assign key_o       = key_q;
  assign quot_o      = quot;
  assign digit_o     = rem[DigitW-1:0];

endmodule

/* src/dlrs_hist.sv */
// digit histogram with prefix sum and scatter position countdown
`timescale 1ns / 1ps
module dlrs_hist #(
  parameter int MAX_KEYS = dlrs_pkg::DefMaxKeys
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dlrs_pkg::hist_ctl_t               ctl_i,
  output logic [$clog2(MAX_KEYS+1)-1:0]     pos_o
);
  import dlrs_pkg::*;

  localparam int CW = $clog2(MAX_KEYS + 1);

  logic [CW-1:0]     counts_q [Radix];
  logic [DigitW-1:0] prev_idx;

  assign prev_idx = DigitW'(ctl_i.idx - 1'b1);

  // one histogram operation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Radix; i++) counts_q[i] <= '0;
    end else begin
      priority if (ctl_i.clr) begin
        for (int i = 0; i < Radix; i++) counts_q[i] <= '0;
      end else if (ctl_i.inc) begin
        counts_q[ctl_i.digit] <= counts_q[ctl_i.digit] + CW'(1);
      end else if (ctl_i.pfx) begin
        counts_q[ctl_i.idx] <= counts_q[ctl_i.idx] + counts_q[prev_idx];
      end else if (ctl_i.dec) begin
        counts_q[ctl_i.digit] <= counts_q[ctl_i.digit] - CW'(1);
      end
    end
  end

  // slot for the key being scattered
  assign pos_o = counts_q[ctl_i.digit] - CW'(1);

endmodule

/* src/decimal_lsd_radix_sort.sv */
// top level of the decimal lsd radix sorter
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------
//  in      | in_valid_i  | in_stall_o   | key_in_i, last_in_i
//  out     | out_valid_o | out_stall_i  | key_out_o, last_out_o, overflow_o
//
// loading takes a key whenever input is valid; sorting makes one pass per
// decimal digit of the largest key: histogram, prefix sum and scatter into
// the other key memory. unloading holds each key until taken, then reads
// the next. reset clears control and the histogram; the key memories need
// no clearing. a stalled output holds; input is stalled outside loading.
`timescale 1ns / 1ps
module decimal_lsd_radix_sort #(
  parameter int MAX_KEYS = dlrs_pkg::DefMaxKeys,
  parameter int KEY_BITS = dlrs_pkg::DefKeyBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dlrs_pkg::KeyW-1:0] key_in_i,
  input  logic                      last_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dlrs_pkg::KeyW-1:0] key_out_o,
  output logic                      last_out_o,
  output logic                      overflow_o
);
  import dlrs_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int EW = 2 * KEY_BITS;

  state_e              state_q, state_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [KEY_BITS-1:0] max_q, max_d;
  logic [KEY_BITS-1:0] nmax_q, nmax_d;
  logic                drop_q, drop_d;
  logic                src_q, src_d;
  logic                rd_v_q, rd_v_d;
  logic [DigitW-1:0]   pidx_q, pidx_d;
  logic                oval_q, oval_d;
  logic [KeyW-1:0]     okey_q, okey_d;
  logic                olast_q, olast_d;
  logic                oovf_q, oovf_d;

  logic [EW-1:0]       mem_a_q [MAX_KEYS];
  logic [EW-1:0]       mem_b_q [MAX_KEYS];
  logic [EW-1:0]       rd_a_q, rd_b_q, rdata;
  logic                wa_en, wb_en;
  logic [AW-1:0]       wa_addr, wb_addr;
  logic [EW-1:0]       wa_data, wb_data;

  logic [KEY_BITS-1:0] key_k;
  logic [CW-1:0]       cnt_m1;
  logic [AW-1:0]       last_addr;
  logic                in_acc;
  logic                div_v;
  logic [KEY_BITS-1:0] div_key, div_quot;
  logic [DigitW-1:0]   div_digit;
  logic [CW-1:0]       pos;
  logic                scat_ph;
  hist_ctl_t           hctl;

  assign key_k     = KEY_BITS'(key_in_i);
  assign cnt_m1    = cnt_q - CW'(1);
  assign last_addr = cnt_m1[AW-1:0];
  assign in_acc    = in_valid_i && (state_q == ST_LOAD);
  assign rdata     = src_q ? rd_b_q : rd_a_q;
  assign scat_ph   = (state_q == ST_SCAT) || (state_q == ST_SCAT_DRAIN);

  // key memories, ping-pong between passes
  always_ff @(posedge clk_i) begin
    if (wa_en) mem_a_q[wa_addr] <= wa_data;
    if (wb_en) mem_b_q[wb_addr] <= wb_data;
    rd_a_q <= mem_a_q[ptr_q];
    rd_b_q <= mem_b_q[ptr_q];
  end

  dlrs_div10 #(.KEY_BITS(KEY_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rd_v_q),
    .key_i      (rdata[EW-1 -: KEY_BITS]),
    .quot_i     (rdata[KEY_BITS-1:0]),
    .out_valid_o(div_v),
    .key_o      (div_key),
    .quot_o     (div_quot),
    .digit_o    (div_digit)
  );

  dlrs_hist #(.MAX_KEYS(MAX_KEYS)) u_hist (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (hctl),
    .pos_o (pos)
  );

  // memory write ports: loading and scatter
  always_comb begin
    wa_en   = 1'b0;
    wa_addr = pos[AW-1:0];
    wa_data = {div_key, div_quot};
    wb_en   = div_v && scat_ph && !src_q;
    wb_addr = pos[AW-1:0];
    wb_data = {div_key, div_quot};
    if (in_acc && (cnt_q < CW'(MAX_KEYS))) begin
      wa_en   = 1'b1;
      wa_addr = cnt_q[AW-1:0];
      wa_data = {key_k, key_k};
    end else if (div_v && scat_ph && src_q) begin
      wa_en = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      ptr_q   <= '0;
      cnt_q   <= '0;
      max_q   <= '0;
      nmax_q  <= '0;
      drop_q  <= 1'b0;
      src_q   <= 1'b0;
      rd_v_q  <= 1'b0;
      pidx_q  <= '0;
      oval_q  <= 1'b0;
      olast_q <= 1'b0;
      oovf_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      max_q   <= max_d;
      nmax_q  <= nmax_d;
      drop_q  <= drop_d;
      src_q   <= src_d;
      rd_v_q  <= rd_v_d;
      pidx_q  <= pidx_d;
      oval_q  <= oval_d;
      olast_q <= olast_d;
      oovf_q  <= oovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    okey_q <= okey_d;
  end

  // next state and sequencing
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    max_d   = max_q;
    nmax_d  = nmax_q;
    drop_d  = drop_q;
    src_d   = src_q;
    rd_v_d  = 1'b0;
    pidx_d  = pidx_q;
    oval_d  = oval_q;
    okey_d  = okey_q;
    olast_d = olast_q;
    oovf_d  = oovf_q;
    hctl        = '0;
    hctl.digit  = div_digit;
    hctl.idx    = pidx_q;
    hctl.inc    = div_v && !scat_ph;
    hctl.dec    = div_v && scat_ph;

    // track the largest quotient for the next pass
    if (div_v && scat_ph && (div_quot > nmax_q)) nmax_d = div_quot;

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CW'(MAX_KEYS)) begin
            cnt_d = cnt_q + CW'(1);
            if (key_k > max_q) max_d = key_k;
          end else begin
            drop_d = 1'b1;
          end
          if (last_in_i) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ptr_d = '0;
        if (max_q == '0) begin
          state_d = ST_OUT_RD;
        end else begin
          hctl.clr = 1'b1;
          state_d  = ST_HIST;
        end
      end
      ST_HIST: begin
        rd_v_d = 1'b1;
        if (ptr_q == last_addr) state_d = ST_HIST_DRAIN;
        else ptr_d = ptr_q + AW'(1);
      end
      ST_HIST_DRAIN: begin
        if (!rd_v_q && !div_v) begin
          pidx_d  = DigitW'(1);
          state_d = ST_PREFIX;
        end
      end
      ST_PREFIX: begin
        hctl.pfx = 1'b1;
        if (pidx_q == DigitW'(Radix - 1)) begin
          ptr_d   = last_addr;
          nmax_d  = '0;
          state_d = ST_SCAT;
        end else begin
          pidx_d = pidx_q + DigitW'(1);
        end
      end
      ST_SCAT: begin
        rd_v_d = 1'b1;
        if (ptr_q == '0) state_d = ST_SCAT_DRAIN;
        else ptr_d = ptr_q - AW'(1);
      end
      ST_SCAT_DRAIN: begin
        if (!rd_v_q && !div_v) begin
          src_d   = !src_q;
          max_d   = nmax_q;
          state_d = ST_CHECK;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        oval_d  = 1'b1;
        okey_d  = KeyW'(rdata[EW-1 -: KEY_BITS]);
        olast_d = (ptr_q == last_addr);
        oovf_d  = drop_q;
        state_d = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (!out_stall_i) begin
          oval_d = 1'b0;
          if (olast_q) begin
            cnt_d   = '0;
            max_d   = '0;
            drop_d  = 1'b0;
            src_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            ptr_d   = ptr_q + AW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = oval_q;
  assign key_out_o   = okey_q;
  assign last_out_o  = olast_q;
  assign overflow_o  = oovf_q;

endmodule

/* src/dlrs_checker.sv */
// port-level checks of the radix sorter and their bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dlrs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      last_in_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [dlrs_pkg::KeyW-1:0] key_out_o,
  input logic                      last_out_o,
  input logic                      overflow_o
);
  logic out_done;
  logic in_last;

  assign out_done = out_valid_o && !out_stall_i && last_out_o;
  assign in_last  = in_valid_i && !in_stall_o && last_in_i;

  // a stalled item holds
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(key_out_o) && $stable(overflow_o))
  // no loading while results are shown
  `ASSERT_IMP(a_no_load_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  // final input item closes the loader
  `ASSERT_NXT(a_load_end, clk_i, rst_ni, in_last, in_stall_o)
  // final item ends the run
  `ASSERT_NXT(a_run_end, clk_i, rst_ni, out_done, !out_valid_o)
  // loader opens after the run
  `ASSERT_NXT(a_reload, clk_i, rst_ni, out_done, !in_stall_o)

endmodule

bind decimal_lsd_radix_sort dlrs_checker u_dlrs_checker (.*);

/* test/decimal_lsd_radix_sort_test.sv */
// self-checking testbench of the decimal lsd radix sorter
`timescale 1ns / 1ps
module decimal_lsd_radix_sort_test;
  import dlrs_pkg::*;

  localparam int Cap = DefMaxKeys;
  localparam logic [KeyW-1:0] KeyMax = {KeyW{1'b1}};

  typedef struct {
    logic [KeyW-1:0] key;
    logic            last;
    int unsigned     send_idle;
    int unsigned     recv_stall;
  } key_item_t;

  typedef struct {
    logic [KeyW-1:0] key;
    logic            last;
    logic            ovf;
  } sorted_key_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [KeyW-1:0] key_in_i = '0;
  logic            last_in_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [KeyW-1:0] key_out_o;
  logic            last_out_o;
  logic            overflow_o;

  key_item_t       pending_keys[$];
  sorted_key_t     sorted_expect[$];
  logic [KeyW-1:0] held_keys[$];
  logic            held_dropped = 1'b0;
  key_item_t       cur_item;
  bit              item_taken = 1'b0;
  int unsigned     stall_pct = 0;
  int              error_count = 0;

  decimal_lsd_radix_sort dut (.*);

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // load one key into the predicted buffer, sort and emit on last
  task automatic predict_sorted(input key_item_t it);
    logic [KeyW-1:0] tmp;
    int j;
    sorted_key_t s;
    if (held_keys.size() < Cap) held_keys.push_back(it.key);
    else held_dropped = 1'b1;
    if (it.last) begin
      for (int i = 1; i < held_keys.size(); i++) begin
        tmp = held_keys[i];
        j = i - 1;
        while (j >= 0 && held_keys[j] > tmp) begin
          held_keys[j+1] = held_keys[j];
          j--;
        end
        held_keys[j+1] = tmp;
      end
      foreach (held_keys[i]) begin
        s.key  = held_keys[i];
        s.last = (i == held_keys.size() - 1);
        s.ovf  = held_dropped;
        sorted_expect.push_back(s);
      end
      held_keys.delete();
      held_dropped = 1'b0;
    end
  endtask

  // input acceptance and output check at the rising edge
  always @(posedge clk_i) begin
    sorted_key_t e;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_sorted(cur_item);
      stall_pct = cur_item.recv_stall;
      item_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected item key %0d", key_out_o));
      end else begin
        e = sorted_expect.pop_front();
        if (key_out_o !== e.key)
          report_mismatch($sformatf("key %0d, wanted %0d", key_out_o, e.key));
        if (last_out_o !== e.last)
          report_mismatch($sformatf("last %b, wanted %b", last_out_o, e.last));
        if (overflow_o !== e.ovf)
          report_mismatch($sformatf("overflow %b, wanted %b", overflow_o, e.ovf));
      end
    end
  end

  // driver and receiver stall at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        item_taken = 1'b0;
        if (pending_keys.size() > 0 &&
            $urandom_range(99, 0) >= pending_keys[0].send_idle) begin
          cur_item = pending_keys.pop_front();
          key_in_i  <= cur_item.key;
          last_in_i <= cur_item.last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  task automatic add_key(input logic [KeyW-1:0] k, input logic l, input int ph);
    key_item_t it;
    it.key = k;
    it.last = l;
    it.send_idle  = (ph == 1) ? 74 : (ph == 3) ? 13 : 0;
    it.recv_stall = (ph == 2) ? 74 : (ph == 3) ? 13 : 0;
    pending_keys.push_back(it);
  endtask

  function automatic logic [KeyW-1:0] rand_key();
    int unsigned lim;
    case ($urandom_range(3, 0))
      0: return KeyW'($urandom_range(9, 0));
      1: return KeyW'($urandom);
      default: begin
        lim = 10 ** $urandom_range(6, 1);
        return KeyW'($urandom % lim);
      end
    endcase
  endfunction

  initial begin
    int n, total, ph;
    // directed: single keys at both extremes, mixed digit lengths, duplicates
    add_key('0, 1'b1, 0);
    add_key(KeyMax, 1'b1, 0);
    add_key(KeyMax, 1'b0, 0);
    add_key(20'd100, 1'b0, 0);
    add_key(20'd9, 1'b0, 0);
    add_key('0, 1'b0, 0);
    add_key(20'd10, 1'b0, 0);
    add_key(20'd99, 1'b1, 0);
    add_key(20'd7, 1'b0, 0);
    add_key(20'd7, 1'b0, 0);
    add_key('0, 1'b0, 0);
    add_key('0, 1'b1, 0);
    // full buffer with dropped keys, the last one dropped too
    for (int i = 0; i < Cap + 3; i++) add_key(rand_key(), i == Cap + 2, 2);
    // exactly full buffer
    for (int i = 0; i < Cap; i++) add_key(rand_key(), i == Cap - 1, 1);
    total = pending_keys.size();
    ph = 0;
    while (total < 360) begin
      if ($urandom_range(9, 0) == 0) n = $urandom_range(Cap + 4, 20);
      else n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) add_key(rand_key(), i == n - 1, ph);
      total += n;
      ph = (ph + 1) % 4;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_keys.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    stall_pct = 0;
    wait (sorted_expect.size() == 0);
    repeat (300) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
